// ----- hdl/lni_pkg.sv -----
package lni_pkg;

	localparam int FIELD_W    = 16;
	localparam int COUNT_W    = 3;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 16;

	// quotient bits resolved per divider stage
	localparam int STEP_BITS  = 2;
	localparam int DIV_STAGES = FIELD_W / STEP_BITS;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ROW_LENGTH = 2'd0,
		CFG_ROW_COUNT  = 2'd1,
		CFG_PERIODIC   = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [FIELD_W-1:0] row_length;
		logic [FIELD_W-1:0] row_count;
		logic               periodic;
	} cfg_t;

	typedef struct packed {
		logic [FIELD_W-1:0] site;
	} query_t;

	typedef struct packed {
		logic [FIELD_W-1:0] slot_zero;
		logic [FIELD_W-1:0] slot_one;
		logic [FIELD_W-1:0] slot_two;
		logic [FIELD_W-1:0] slot_three;
		logic [COUNT_W-1:0] neighbor_count;
		logic               out_of_range;
	} result_t;

	// acc starts as the site and ends as the row, rem ends as the column
	typedef struct packed {
		logic [FIELD_W-1:0] site;
		logic [FIELD_W-1:0] acc;
		logic [FIELD_W-1:0] rem;
		logic [FIELD_W-1:0] wrap;
		logic               out_of_range;
	} div_t;

endpackage

// ----- hdl/lni_stream_if.sv -----
interface lni_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/lni_front.sv -----
module lni_front (
	input  logic          clk,
	input  logic          arst_n,
	input  lni_pkg::cfg_t cfg,
	lni_stream_if.sink    up,
	lni_stream_if.source  dn
);

	logic                        v_s1;
	logic [lni_pkg::FIELD_W-1:0] site_s1;
	logic [2*lni_pkg::FIELD_W-1:0] prod_s1;
	logic                        v_s2;
	lni_pkg::div_t               div_s2;
	lni_pkg::div_t               div_next;
	logic                        ready_s1;
	logic                        ready_s2;

	assign ready_s2 = !v_s2 || dn.ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign up.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && up.valid) begin
			site_s1 <= up.payload.site;
			prod_s1 <= (2*lni_pkg::FIELD_W)'(cfg.row_length)
				* (2*lni_pkg::FIELD_W)'(cfg.row_count);
		end
	end

	always_comb begin
		div_next.site         = site_s1;
		div_next.acc          = site_s1;
		div_next.rem          = '0;
		// low bits of width * (height - 1), enough for 16-bit slot values
		div_next.wrap         = prod_s1[lni_pkg::FIELD_W-1:0] - cfg.row_length;
		div_next.out_of_range = ((2*lni_pkg::FIELD_W)'(site_s1) >= prod_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			div_s2 <= div_next;
		end
	end

	assign dn.valid   = v_s2;
	assign dn.payload = div_s2;

endmodule

// ----- hdl/lni_div_stage.sv -----
module lni_div_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lni_pkg::FIELD_W-1:0] row_length,
	lni_stream_if.sink                  up,
	lni_stream_if.source                dn
);

	logic          v_s1;
	lni_pkg::div_t div_s1;
	lni_pkg::div_t div_next;
	logic          ready_s1;

	assign ready_s1 = !v_s1 || dn.ready;
	assign up.ready = ready_s1;

	// restoring division, one quotient bit per step
	always_comb begin
		logic [lni_pkg::FIELD_W:0]   trial;
		logic [lni_pkg::FIELD_W-1:0] acc;
		logic [lni_pkg::FIELD_W-1:0] rem;
		acc = up.payload.acc;
		rem = up.payload.rem;
		for (int i = 0; i < lni_pkg::STEP_BITS; i++) begin
			trial = {rem, acc[lni_pkg::FIELD_W-1]};
			acc   = {acc[lni_pkg::FIELD_W-2:0], 1'b0};
			if (trial >= {1'b0, row_length}) begin
				trial  = trial - {1'b0, row_length};
				acc[0] = 1'b1;
			end
			rem = trial[lni_pkg::FIELD_W-1:0];
		end
		div_next     = up.payload;
		div_next.acc = acc;
		div_next.rem = rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && up.valid) begin
			div_s1 <= div_next;
		end
	end

	assign dn.valid   = v_s1;
	assign dn.payload = div_s1;

endmodule

// ----- hdl/lni_neighbor.sv -----
module lni_neighbor (
	input  logic          clk,
	input  logic          arst_n,
	input  lni_pkg::cfg_t cfg,
	lni_stream_if.sink    up,
	lni_stream_if.source  dn
);

	typedef enum logic [1:0] {
		DIR_L = 2'd0,
		DIR_D = 2'd1,
		DIR_R = 2'd2,
		DIR_U = 2'd3
	} dir_t;

	typedef struct packed {
		logic [3:0][lni_pkg::FIELD_W-1:0] val;
		logic                             col_first;
		logic                             col_last;
		logic                             row_first;
		logic                             row_last;
		logic                             chain;
		logic                             out_of_range;
	} cand_t;

	logic             v_s1;
	cand_t            cand_s1;
	cand_t            cand_next;
	logic             v_s2;
	lni_pkg::result_t res_s2;
	lni_pkg::result_t res_next;
	logic             ready_s1;
	logic             ready_s2;

	assign ready_s2 = !v_s2 || dn.ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign up.ready = ready_s1;

	// candidate indices, wrapped in periodic mode
	always_comb begin
		logic [lni_pkg::FIELD_W-1:0] s;
		logic [lni_pkg::FIELD_W-1:0] w;
		logic [lni_pkg::FIELD_W-1:0] row;
		logic [lni_pkg::FIELD_W-1:0] col;
		s   = up.payload.site;
		w   = cfg.row_length;
		row = up.payload.acc;
		col = up.payload.rem;
		cand_next.col_first    = (col == '0);
		cand_next.col_last     = (col == w - 16'd1);
		cand_next.row_first    = (row == '0);
		cand_next.row_last     = (row == cfg.row_count - 16'd1);
		cand_next.chain        = (cfg.row_count == 16'd1);
		cand_next.out_of_range = up.payload.out_of_range;
		cand_next.val[DIR_L]   = s - 16'd1;
		cand_next.val[DIR_R]   = s + 16'd1;
		cand_next.val[DIR_U]   = s - w;
		cand_next.val[DIR_D]   = s + w;
		if (cfg.periodic) begin
			if (cand_next.col_first) begin
				cand_next.val[DIR_L] = s + (w - 16'd1);
			end
			if (cand_next.col_last) begin
				cand_next.val[DIR_R] = s - col;
			end
			if (cand_next.row_first) begin
				cand_next.val[DIR_U] = s + up.payload.wrap;
			end
			if (cand_next.row_last) begin
				cand_next.val[DIR_D] = s - up.payload.wrap;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && up.valid) begin
			cand_s1 <= cand_next;
		end
	end

	// edge-dependent order in open mode, missing neighbors dropped and the rest packed low
	always_comb begin
		dir_t                          order [4];
		logic [2:0]                    len;
		dir_t                          vert;
		logic [3:0]                    has;
		logic [lni_pkg::FIELD_W-1:0]   slot [4];
		logic [lni_pkg::COUNT_W-1:0]   cnt;
		for (int k = 0; k < 4; k++) begin
			order[k] = DIR_L;
			slot[k]  = '0;
		end
		len  = 3'd0;
		cnt  = '0;
		vert = cand_s1.row_first ? DIR_D : DIR_U;
		has[DIR_L] = !cand_s1.col_first;
		has[DIR_R] = !cand_s1.col_last;
		has[DIR_U] = !cand_s1.row_first;
		has[DIR_D] = !cand_s1.row_last;
		if (cand_s1.out_of_range) begin
			cnt = '0;
		end else if (cfg.periodic) begin
			if (cand_s1.chain) begin
				slot[0] = cand_s1.val[DIR_L];
				slot[1] = cand_s1.val[DIR_R];
				cnt     = 3'd2;
			end else begin
				slot[0] = cand_s1.val[DIR_L];
				slot[1] = cand_s1.val[DIR_D];
				slot[2] = cand_s1.val[DIR_R];
				slot[3] = cand_s1.val[DIR_U];
				cnt     = 3'd4;
			end
		end else begin
			if (cand_s1.row_first || cand_s1.row_last) begin
				if (cand_s1.col_first) begin
					order[0] = DIR_R;
					order[1] = vert;
					len      = 3'd2;
				end else if (cand_s1.col_last) begin
					order[0] = DIR_L;
					order[1] = vert;
					len      = 3'd2;
				end else begin
					order[0] = DIR_L;
					order[1] = vert;
					order[2] = DIR_R;
					len      = 3'd3;
				end
			end else if (cand_s1.col_first) begin
				order[0] = DIR_U;
				order[1] = DIR_D;
				order[2] = DIR_R;
				len      = 3'd3;
			end else if (cand_s1.col_last) begin
				order[0] = DIR_L;
				order[1] = DIR_D;
				order[2] = DIR_U;
				len      = 3'd3;
			end else begin
				order[0] = DIR_L;
				order[1] = DIR_D;
				order[2] = DIR_R;
				order[3] = DIR_U;
				len      = 3'd4;
			end
			for (int k = 0; k < 4; k++) begin
				if (3'(k) < len && has[order[k]]) begin
					slot[cnt[1:0]] = cand_s1.val[order[k]];
					cnt            = cnt + 3'd1;
				end
			end
		end
		res_next.slot_zero      = slot[0];
		res_next.slot_one       = slot[1];
		res_next.slot_two       = slot[2];
		res_next.slot_three     = slot[3];
		res_next.neighbor_count = cnt;
		res_next.out_of_range   = cand_s1.out_of_range;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			res_s2 <= res_next;
		end
	end

	assign dn.valid   = v_s2;
	assign dn.payload = res_s2;

	a_oor_empty: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && res_s2.out_of_range |-> res_s2.neighbor_count == '0
			&& res_s2.slot_zero == '0 && res_s2.slot_one == '0
			&& res_s2.slot_two == '0 && res_s2.slot_three == '0)
		else $error("out of range result carries neighbors");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> res_s2.neighbor_count <= 3'd4)
		else $error("neighbor count above four");

	a_unused_slots: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && res_s2.neighbor_count < 3'd4 |-> res_s2.slot_three == '0
			&& (res_s2.neighbor_count >= 3'd3 || res_s2.slot_two == '0)
			&& (res_s2.neighbor_count >= 3'd2 || res_s2.slot_one == '0))
		else $error("unused slot not zero");

endmodule

// ----- hdl/lattice_neighbor_index_top.sv -----
// Nearest-neighbor lookup on a row-major lattice: each query transaction carries a site
// index and yields one result transaction with up to four neighbor indices, their count
// and an out-of-range flag, under the row_length, row_count and periodic registers.
// One query is taken every cycle while the pipeline is not stalled; each result passes
// through the split of the site into row and column, done by a 16-bit restoring
// divider spread over eight stages of two quotient bits each, behind a two-stage front
// end (size product, range check) and a two-stage neighbor selector. Every stage holds
// under backpressure, so empty stages keep filling while a result waits to be taken.
// Registers may be written only while no query is in flight.
module lattice_neighbor_index_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [lni_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lni_pkg::CFG_DATA_W-1:0]  cfg_data,
	lni_stream_if.sink                      query,
	lni_stream_if.source                    result
);

	lni_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_length <= 16'd4;
			cfg_q.row_count  <= 16'd4;
			cfg_q.periodic   <= 1'b0;
		end else if (cfg_write) begin
			unique case (lni_pkg::cfg_index_t'(cfg_index))
				lni_pkg::CFG_ROW_LENGTH: cfg_q.row_length <= cfg_data;
				lni_pkg::CFG_ROW_COUNT:  cfg_q.row_count  <= cfg_data;
				lni_pkg::CFG_PERIODIC:   cfg_q.periodic   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	lni_stream_if #(.payload_t(lni_pkg::div_t)) div_link [lni_pkg::DIV_STAGES+1] ();

	lni_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.up     (query),
		.dn     (div_link[0])
	);

	for (genvar i = 0; i < lni_pkg::DIV_STAGES; i++) begin : g_div
		lni_div_stage u_div (
			.clk        (clk),
			.arst_n     (arst_n),
			.row_length (cfg_q.row_length),
			.up         (div_link[i]),
			.dn         (div_link[i+1])
		);
	end

	lni_neighbor u_neighbor (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.up     (div_link[lni_pkg::DIV_STAGES]),
		.dn     (result)
	);

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!query.ready |-> result.valid && !result.ready)
		else $error("query blocked while pipeline can advance");

endmodule
